// File: rtl/icsp_pkg.sv
// ----------------------------------------------------------------------------
// icsp_pkg
// Shared types and codes for the image container stream parser.
// ----------------------------------------------------------------------------
package icsp_pkg;

  typedef enum logic [3:0] {
    PH_ID, PH_LEN, PH_SKIP, PH_CRED_FIX, PH_CREATOR,
    PH_DURATION, PH_FIXED, PH_CAPTION, PH_TAGS, PH_CONTENT
  } phase_t;

  typedef enum logic [3:0] {
    K_ANIM    = 4'd0,
    K_WIDTH   = 4'd1,
    K_HEIGHT  = 4'd2,
    K_CAPTION = 4'd3,
    K_TAG     = 4'd4,
    K_TAGEND  = 4'd5,
    K_CREATOR = 4'd6,
    K_PIXEL   = 4'd7,
    K_DONE    = 4'd8,
    K_TRUNC   = 4'd9
  } kind_t;

  localparam logic [7:0] ID_CREDITS = 8'h02;
  localparam logic [7:0] ID_ANIM    = 8'h03;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_NUL     = 8'h00;

  // One queued entry: up to two results made by one input byte.
  typedef struct packed {
    logic         two;
    logic [3:0]   kind0;
    logic [63:0]  value0;
    logic         fin0;
    logic [3:0]   kind1;
    logic [63:0]  value1;
    logic         fin1;
  } res_pair_t;

endpackage

// File: rtl/icsp_if.sv
// ----------------------------------------------------------------------------
// icsp_in_if / icsp_out_if
// Valid/ready channels for file bytes and parse results.
// ----------------------------------------------------------------------------
interface icsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;
  modport source (output valid, data_byte, end_of_file, input ready);
  modport sink   (input valid, data_byte, end_of_file, output ready);
endinterface

interface icsp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [63:0] value;
  logic        final_res;
  modport source (output valid, kind, value, final_res, input ready);
  modport sink   (input valid, kind, value, final_res, output ready);
endinterface

// File: rtl/icsp_front.sv
// ----------------------------------------------------------------------------
// icsp_front
// Byte classifier: walks the block structure and forms result pairs.
// ----------------------------------------------------------------------------
module icsp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [7:0]           in_byte,
  input  logic                 in_eof,
  input  logic                 q_full,
  output logic                 in_ready,
  output logic                 push,
  output icsp_pkg::res_pair_t  push_data
);

  icsp_pkg::phase_t phase, phase_next;
  logic [3:0]  field_bytes, field_bytes_next;
  logic [7:0]  block_kind, block_kind_next;
  logic [63:0] block_left, block_left_next;
  logic [63:0] word_assembly, word_assembly_next;
  logic [63:0] inner_header_size, inner_header_size_next;
  logic [63:0] inner_offset, inner_offset_next;
  logic [15:0] pixel_bytes, pixel_bytes_next;
  logic [1:0]  pixel_phase, pixel_phase_next;
  logic        credits_seen, credits_seen_next;
  logic        stopped, stopped_next;

  // result list built in order
  logic [1:0]  n;
  logic [3:0]  rk [2];
  logic [63:0] rv [2];
  logic        rf [2];
  logic        fire;
  logic [63:0] asm_word;
  logic [5:0]  fo;
  logic [63:0] left_dec;

  assign in_ready = !q_full;
  assign fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= icsp_pkg::PH_ID;
      field_bytes <= '0;
      block_kind <= '0;
      block_left <= '0;
      word_assembly <= '0;
      inner_header_size <= '0;
      inner_offset <= '0;
      pixel_bytes <= '0;
      pixel_phase <= '0;
      credits_seen <= 1'b0;
      stopped <= 1'b0;
    end else if (fire) begin
      phase <= phase_next;
      field_bytes <= field_bytes_next;
      block_kind <= block_kind_next;
      block_left <= block_left_next;
      word_assembly <= word_assembly_next;
      inner_header_size <= inner_header_size_next;
      inner_offset <= inner_offset_next;
      pixel_bytes <= pixel_bytes_next;
      pixel_phase <= pixel_phase_next;
      credits_seen <= credits_seen_next;
      stopped <= stopped_next;
    end
  end

  always_comb begin
    phase_next = phase;
    field_bytes_next = field_bytes;
    block_kind_next = block_kind;
    block_left_next = block_left;
    word_assembly_next = word_assembly;
    inner_header_size_next = inner_header_size;
    inner_offset_next = inner_offset;
    pixel_bytes_next = pixel_bytes;
    pixel_phase_next = pixel_phase;
    credits_seen_next = credits_seen;
    stopped_next = stopped;
    n = 2'd0;
    rk[0] = '0; rv[0] = '0; rf[0] = 1'b0;
    rk[1] = '0; rv[1] = '0; rf[1] = 1'b0;
    asm_word = '0;
    fo = inner_offset[5:0] - 6'd4;
    left_dec = block_left - 64'd1;

    if (!stopped) begin
      if (phase == icsp_pkg::PH_ID) begin
        block_kind_next = in_byte;
        field_bytes_next = '0;
        word_assembly_next = '0;
        phase_next = icsp_pkg::PH_LEN;
      end else if (phase == icsp_pkg::PH_LEN) begin
        asm_word = word_assembly | ({56'd0, in_byte} << {field_bytes[2:0], 3'b000});
        word_assembly_next = asm_word;
        field_bytes_next = field_bytes + 4'd1;
        if (field_bytes == 4'd7) begin
          block_left_next = asm_word;
          field_bytes_next = '0;
          word_assembly_next = '0;
          if (block_kind == icsp_pkg::ID_ANIM) begin
            rk[n[0]] = icsp_pkg::K_ANIM; n = n + 2'd1;
            inner_offset_next = '0;
            inner_header_size_next = '0;
            pixel_phase_next = '0;
            pixel_bytes_next = '0;
            phase_next = icsp_pkg::PH_DURATION;
          end else if (block_kind == icsp_pkg::ID_CREDITS) begin
            credits_seen_next = 1'b1;
            phase_next = icsp_pkg::PH_CRED_FIX;
          end else begin
            phase_next = icsp_pkg::PH_SKIP;
          end
          if (asm_word == 64'd0) begin
            phase_next = icsp_pkg::PH_ID;
            if (block_kind == icsp_pkg::ID_ANIM && credits_seen) begin
              stopped_next = 1'b1;
              rk[n[0]] = icsp_pkg::K_DONE; rf[n[0]] = 1'b1; n = n + 2'd1;
            end
          end
        end
      end else begin
        case (phase)
          icsp_pkg::PH_CRED_FIX: begin
            field_bytes_next = field_bytes + 4'd1;
            if (field_bytes == 4'd13) phase_next = icsp_pkg::PH_CREATOR;
          end
          icsp_pkg::PH_CREATOR: begin
            rk[0] = icsp_pkg::K_CREATOR; rv[0] = {56'd0, in_byte}; n = 2'd1;
          end
          icsp_pkg::PH_DURATION: begin
            field_bytes_next = field_bytes + 4'd1;
            if (field_bytes == 4'd7) begin
              field_bytes_next = '0;
              word_assembly_next = '0;
              phase_next = icsp_pkg::PH_FIXED;
            end
          end
          icsp_pkg::PH_FIXED: begin
            // fixed part is offsets 0..35 only; phase leaves at 35
            if (inner_offset[5:0] >= 6'd4) begin
              asm_word = word_assembly | ({56'd0, in_byte} << {fo[2:0], 3'b000});
              word_assembly_next = asm_word;
              if (fo[2:0] == 3'd7) begin
                word_assembly_next = '0;
                case (fo[5:3])
                  3'd0: inner_header_size_next = asm_word;
                  3'd2: begin
                    rk[0] = icsp_pkg::K_WIDTH; rv[0] = asm_word; n = 2'd1;
                  end
                  3'd3: begin
                    rk[0] = icsp_pkg::K_HEIGHT; rv[0] = asm_word; n = 2'd1;
                    phase_next = icsp_pkg::PH_CAPTION;
                  end
                  default: ;
                endcase
              end
            end
            inner_offset_next = inner_offset + 64'd1;
          end
          icsp_pkg::PH_CAPTION, icsp_pkg::PH_TAGS, icsp_pkg::PH_CONTENT: begin
            if (phase == icsp_pkg::PH_CONTENT || inner_offset >= inner_header_size) begin
              phase_next = icsp_pkg::PH_CONTENT;
              if (pixel_phase < 2'd2) begin
                pixel_bytes_next = {pixel_bytes[7:0], in_byte};
                pixel_phase_next = pixel_phase + 2'd1;
              end else begin
                pixel_phase_next = '0;
                rk[0] = icsp_pkg::K_PIXEL;
                rv[0] = {40'd0, pixel_bytes, in_byte}; n = 2'd1;
              end
            end else if (phase == icsp_pkg::PH_CAPTION) begin
              if (in_byte == icsp_pkg::CH_NEWLINE) phase_next = icsp_pkg::PH_TAGS;
              else begin
                rk[0] = icsp_pkg::K_CAPTION; rv[0] = {56'd0, in_byte}; n = 2'd1;
              end
            end else if (in_byte == icsp_pkg::CH_NUL) begin
              rk[0] = icsp_pkg::K_TAGEND; n = 2'd1;
            end else begin
              rk[0] = icsp_pkg::K_TAG; rv[0] = {56'd0, in_byte}; n = 2'd1;
            end
            if (phase != icsp_pkg::PH_CONTENT) inner_offset_next = inner_offset + 64'd1;
          end
          default: ;
        endcase
        block_left_next = left_dec;
        if (left_dec == 64'd0) begin
          phase_next = icsp_pkg::PH_ID;
          if (block_kind == icsp_pkg::ID_ANIM && credits_seen) begin
            stopped_next = 1'b1;
            rk[n[0]] = icsp_pkg::K_DONE; rv[n[0]] = '0; rf[n[0]] = 1'b1;
            n = n + 2'd1;
          end
        end
      end
      if (in_eof && !stopped_next) begin
        stopped_next = 1'b1;
        rk[n[0]] = (phase_next == icsp_pkg::PH_ID) ? icsp_pkg::K_DONE : icsp_pkg::K_TRUNC;
        rv[n[0]] = '0; rf[n[0]] = 1'b1;
        n = n + 2'd1;
      end
    end
  end

  assign push = fire && (n != 2'd0);
  assign push_data = '{two: n[1], kind0: rk[0], value0: rv[0], fin0: rf[0],
                       kind1: rk[1], value1: rv[1], fin1: rf[1]};

  a_stop_holds: assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped) else $error("stop flag cleared");
  a_no_push_stopped: assert property (@(posedge clk) disable iff (rst)
    stopped |-> !push) else $error("result after stop");
  a_fin_last: assert property (@(posedge clk) disable iff (rst)
    (push && push_data.two) |-> !push_data.fin0) else $error("final not last");

endmodule

// File: rtl/icsp_back.sv
// ----------------------------------------------------------------------------
// icsp_back
// Two-entry queue of result pairs, drained one result per beat.
// ----------------------------------------------------------------------------
module icsp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  icsp_pkg::res_pair_t  push_data,
  output logic                 q_full,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [3:0]           out_kind,
  output logic [63:0]          out_value,
  output logic                 out_final
);

  icsp_pkg::res_pair_t mem [2];
  logic       wr_ptr, rd_ptr, sub;
  logic [1:0] count;
  logic       pop_item, pop;
  icsp_pkg::res_pair_t head;

  assign head = mem[rd_ptr];
  assign q_full = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_kind  = sub ? head.kind1  : head.kind0;
  assign out_value = sub ? head.value1 : head.value0;
  assign out_final = sub ? head.fin1   : head.fin0;
  assign pop = out_valid && out_ready;
  assign pop_item = pop && (sub || !head.two);

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      sub <= 1'b0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop_item) begin
        rd_ptr <= !rd_ptr;
        sub <= 1'b0;
      end else if (pop) begin
        sub <= 1'b1;
      end
      count <= count + {1'b0, push} - {1'b0, pop_item};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push) else $error("queue overflow");
  a_sub_only_pair: assert property (@(posedge clk) disable iff (rst)
    sub |-> (out_valid && head.two)) else $error("bad second slot");

endmodule

// File: rtl/image_container_stream_parser.sv
// ----------------------------------------------------------------------------
// image_container_stream_parser
// Streaming parser of an animated image container, one file byte per beat.
// ----------------------------------------------------------------------------
// Takes one file byte per cycle while the queue has room; the front classifier
// updates its block walker for each byte and writes up to two results into a
// two-entry queue, which the back end drains at one result per beat. Input
// is accepted every cycle while the queue has room, so throughput is one
// byte per cycle until the queue fills; a byte that produces two results (a
// result plus done/truncated) is drained as two output beats. A byte's results
// are registered into the queue before they reach the output. After done or
// truncated, input is swallowed with no results until reset.
module image_container_stream_parser (
  input logic    clk,
  input logic    rst,
  icsp_in_if.sink    in_ch,
  icsp_out_if.source out_ch
);

  logic                q_full;
  logic                push;
  icsp_pkg::res_pair_t push_data;

  // block walker and result forming
  icsp_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_byte(in_ch.data_byte), .in_eof(in_ch.end_of_file),
    .q_full(q_full), .in_ready(in_ch.ready),
    .push(push), .push_data(push_data)
  );

  // result queue and output serializer
  icsp_back u_back (
    .clk(clk), .rst(rst),
    .push(push), .push_data(push_data), .q_full(q_full),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_kind(out_ch.kind), .out_value(out_ch.value), .out_final(out_ch.final_res)
  );

endmodule
